>>> design/tpz_pkg.sv
// Shared types, constants and the multiply schedule for the torus point renderer.
// Used by the controller, the datapath, the divider and the top level. No dependencies.
package tpz_pkg;

  localparam int MAX_COLS   = 256;
  localparam int MAX_ROWS   = 128;
  localparam int DEPTH_BITS = 16;
  localparam int CELLS      = MAX_COLS * MAX_ROWS;
  localparam int CELL_W     = $clog2(CELLS);
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int W_W        = COL_W + 1;
  localparam int H_W        = ROW_W + 1;
  localparam int SHADE_W    = 4;
  localparam int GLYPH_W    = 7;
  localparam int MEM_W      = DEPTH_BITS + SHADE_W;

  localparam int Q_FRAC     = 14;
  localparam int ONE_Q14    = 16384;
  localparam int ACC_W      = 22;
  localparam int OPA_W      = 22;
  localparam int OPB_W      = 18;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int RAW_W      = 32;

  localparam int DEPTH_NUM_SH = Q_FRAC + DEPTH_BITS - 1;
  localparam int DIVN_W       = DEPTH_NUM_SH + 1;
  localparam int DIVD_W       = 22;
  localparam int DCNT_W       = $clog2(DIVN_W + 1);

  localparam logic signed [ACC_W-1:0] DEN_INIT = ACC_W'(5 * ONE_Q14);
  localparam logic signed [OPB_W-1:0] H_OFS    = OPB_W'(2 * ONE_Q14);
  localparam logic [DEPTH_BITS-1:0]   DEPTH_MAX = '1;

  localparam int STEP_W        = 5;
  localparam logic [STEP_W-1:0] STEP_LUM_LAST = STEP_W'(17);
  localparam logic [STEP_W-1:0] STEP_ROWN     = STEP_W'(19);
  localparam logic [STEP_W-1:0] STEP_BASE     = STEP_W'(20);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLOT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  localparam logic [2:0] REG_A_SIN = 3'd0;
  localparam logic [2:0] REG_A_COS = 3'd1;
  localparam logic [2:0] REG_B_SIN = 3'd2;
  localparam logic [2:0] REG_B_COS = 3'd3;
  localparam logic [2:0] REG_COLS  = 3'd4;
  localparam logic [2:0] REG_ROWS  = 3'd5;

  typedef enum logic [3:0] {
    A_ST, A_CT, A_SP, A_SH, A_CH, A_Q, A_T, A_X, A_C2, A_DX, A_DY, A_ROW
  } opa_sel_t;

  typedef enum logic [2:0] {
    B_H, B_CP, B_SA, B_CA, B_SB, B_CB, B_W, B_HG
  } opb_sel_t;

  typedef enum logic [3:0] {
    D_SH, D_CH, D_Q, D_DEN, D_T, D_XN, D_YN, D_X, D_LUM, D_C2, D_COLN, D_ROWN, D_BASE
  } dst_sel_t;

  typedef enum logic [1:0] {
    DV_DEPTH, DV_COL, DV_ROW
  } div_sel_t;

  typedef struct packed {
    opa_sel_t a_sel;
    opb_sel_t b_sel;
    dst_sel_t dst;
    logic     sub;
  } mul_op_t;

  typedef struct packed {
    logic     load;
    logic     clr;
    logic     mem_rd;
    logic     mul;
    logic     wb;
    mul_op_t  op;
    logic     div_start;
    div_sel_t div_sel;
    logic     addr;
    logic     mem_cmp;
  } dp_cmd_t;

  typedef struct packed {
    logic den_pos;
    logic div_done;
    logic on_screen;
    logic clr_last;
  } dp_sts_t;

  typedef struct packed {
    logic signed [15:0] a_sin;
    logic signed [15:0] a_cos;
    logic signed [15:0] b_sin;
    logic signed [15:0] b_cos;
    logic [W_W-1:0]     w;
    logic [H_W-1:0]     hg;
  } cfg_t;

  // Multiply schedule: products are accumulated (shifted by 14) into the named
  // term; the last three are exact products for the projection and the address.
  function automatic mul_op_t mul_op(input logic [STEP_W-1:0] step);
    mul_op_t o;
    o = '{a_sel: A_ST, b_sel: B_H, dst: D_SH, sub: 1'b0};
    case (step)
      STEP_W'(0):  o = '{A_ST,  B_H,  D_SH,   1'b0};
      STEP_W'(1):  o = '{A_CT,  B_H,  D_CH,   1'b0};
      STEP_W'(2):  o = '{A_ST,  B_CP, D_Q,    1'b0};
      STEP_W'(3):  o = '{A_SH,  B_SA, D_DEN,  1'b0};
      STEP_W'(4):  o = '{A_SP,  B_CA, D_DEN,  1'b0};
      STEP_W'(5):  o = '{A_SH,  B_CA, D_T,    1'b0};
      STEP_W'(6):  o = '{A_SP,  B_SA, D_T,    1'b1};
      STEP_W'(7):  o = '{A_CH,  B_CB, D_XN,   1'b0};
      STEP_W'(8):  o = '{A_T,   B_SB, D_XN,   1'b1};
      STEP_W'(9):  o = '{A_CH,  B_SB, D_YN,   1'b0};
      STEP_W'(10): o = '{A_T,   B_CB, D_YN,   1'b0};
      STEP_W'(11): o = '{A_SP,  B_SA, D_X,    1'b0};
      STEP_W'(12): o = '{A_Q,   B_CA, D_X,    1'b1};
      STEP_W'(13): o = '{A_X,   B_CB, D_LUM,  1'b0};
      STEP_W'(14): o = '{A_Q,   B_SA, D_LUM,  1'b1};
      STEP_W'(15): o = '{A_SP,  B_CA, D_LUM,  1'b1};
      STEP_W'(16): o = '{A_CT,  B_CP, D_C2,   1'b0};
      STEP_W'(17): o = '{A_C2,  B_SB, D_LUM,  1'b1};
      STEP_W'(18): o = '{A_DX,  B_W,  D_COLN, 1'b0};
      STEP_W'(19): o = '{A_DY,  B_HG, D_ROWN, 1'b0};
      STEP_W'(20): o = '{A_ROW, B_W,  D_BASE, 1'b0};
      default:     o = '{A_ST,  B_H,  D_SH,   1'b0};
    endcase
    return o;
  endfunction

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SHADE_W-1:0] code);
    logic [GLYPH_W-1:0] g;
    case (code)
      4'd1:    g = 7'd46;   // '.'
      4'd2:    g = 7'd44;   // ','
      4'd3:    g = 7'd45;   // '-'
      4'd4:    g = 7'd126;  // '~'
      4'd5:    g = 7'd58;   // ':'
      4'd6:    g = 7'd59;   // ';'
      4'd7:    g = 7'd61;   // '='
      4'd8:    g = 7'd33;   // '!'
      4'd9:    g = 7'd42;   // '*'
      4'd10:   g = 7'd35;   // '#'
      4'd11:   g = 7'd36;   // '$'
      4'd12:   g = 7'd64;   // '@'
      default: g = 7'd32;   // blank cell
    endcase
    return g;
  endfunction

endpackage

>>> design/tpz_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on tpz_pkg for the operand widths.
module tpz_div import tpz_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVN_W-1:0] dividend,
  input  logic [DIVD_W-1:0] divisor,
  output logic              done,
  output logic [DIVN_W-1:0] quotient
);

  logic [DIVN_W-1:0] quo_r, quo_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVD_W-1:0] dsr_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              done_r;
  logic [DIVD_W:0]   shifted;
  logic [DIVD_W+1:0] diff;

  always_comb begin
    shifted = {rem_r, quo_r[DIVN_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    if (!diff[DIVD_W+1]) begin
      rem_nxt = diff[DIVD_W-1:0];
      quo_nxt = {quo_r[DIVN_W-2:0], 1'b1};
    end else begin
      rem_nxt = shifted[DIVD_W-1:0];
      quo_nxt = {quo_r[DIVN_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DCNT_W'(DIVN_W);
      end else if (cnt_r != '0) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == DCNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

>>> design/tpz_dp.sv
// Datapath: operand registers, shared multiplier, divider, frame store and results.
// Depends on tpz_pkg and tpz_div; driven by tpz_ctrl through dp_cmd_t.
module tpz_dp import tpz_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd_i,
  input  cfg_t                cfg,
  input  logic [1:0]          in_command,
  input  logic signed [15:0]  in_sin_theta,
  input  logic signed [15:0]  in_cos_theta,
  input  logic signed [15:0]  in_sin_phi,
  input  logic signed [15:0]  in_cos_phi,
  input  logic [CELL_W-1:0]   in_cell_index,
  output dp_sts_t             sts,
  output logic [GLYPH_W-1:0]  res_glyph,
  output logic                res_plotted,
  output logic [CELL_W-1:0]   res_cell_addr
);

  logic signed [15:0] st_r, ct_r, sp_r, cp_r;
  logic [CELL_W-1:0]  idx_r;
  logic               is_read_r;

  logic signed [ACC_W-1:0] sh_r, ch_r, q_r, den_r, t_r, xn_r, yn_r, x_r, lum_r, c2_r;
  logic signed [RAW_W-1:0] coln_r, rown_r;
  logic [CELL_W-1:0]       base_r, addr_r;
  logic signed [PROD_W-1:0] prod_r;

  logic [DEPTH_BITS-1:0] depth_r;
  logic [COL_W-1:0]      col_r;
  logic [ROW_W-1:0]      row_r;
  logic                  col_ok_r, row_ok_r;
  logic                  plotted_r;
  logic [CELL_W-1:0]     clr_addr_r;
  logic [MEM_W-1:0]      rd_data_r;
  logic [MEM_W-1:0]      mem [CELLS];

  logic signed [OPB_W-1:0]  h;
  logic signed [OPA_W-1:0]  opa;
  logic signed [OPB_W-1:0]  opb;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  dx, dy;
  logic signed [ACC_W-1:0]  acc_cur, acc_new;

  logic [DIVN_W-1:0] div_n, div_q;
  logic [DIVD_W-1:0] div_d;
  logic              div_done;
  logic [RAW_W-1:0]  coln_mag, rown_mag;
  logic              q_fits_w, q_fits_h;

  logic [SHADE_W-1:0] shade;
  logic [ACC_W-1:0]   lum_scaled;
  logic               nearer;
  logic               we;
  logic [CELL_W-1:0]  wa, ra;
  logic [MEM_W-1:0]   wd;

  // Operand selection for the shared multiplier.
  assign h  = OPB_W'(cp_r) + H_OFS;
  assign dx = (den_r <<< 1) + xn_r;
  assign dy = (den_r <<< 1) + yn_r;

  always_comb begin
    case (cmd_i.op.a_sel)
      A_ST:    opa = OPA_W'(st_r);
      A_CT:    opa = OPA_W'(ct_r);
      A_SP:    opa = OPA_W'(sp_r);
      A_SH:    opa = sh_r;
      A_CH:    opa = ch_r;
      A_Q:     opa = q_r;
      A_T:     opa = t_r;
      A_X:     opa = x_r;
      A_C2:    opa = c2_r;
      A_DX:    opa = dx;
      A_DY:    opa = dy;
      A_ROW:   opa = signed'(OPA_W'(row_r));
      default: opa = '0;
    endcase
    case (cmd_i.op.b_sel)
      B_H:     opb = h;
      B_CP:    opb = OPB_W'(cp_r);
      B_SA:    opb = OPB_W'(cfg.a_sin);
      B_CA:    opb = OPB_W'(cfg.a_cos);
      B_SB:    opb = OPB_W'(cfg.b_sin);
      B_CB:    opb = OPB_W'(cfg.b_cos);
      B_W:     opb = signed'(OPB_W'(cfg.w));
      B_HG:    opb = signed'(OPB_W'(cfg.hg));
      default: opb = '0;
    endcase
  end

  assign prod    = opa * opb;
  assign prod_sh = prod_r >>> Q_FRAC;
  assign term    = prod_sh[ACC_W-1:0];

  always_comb begin
    case (cmd_i.op.dst)
      D_SH:    acc_cur = sh_r;
      D_CH:    acc_cur = ch_r;
      D_Q:     acc_cur = q_r;
      D_DEN:   acc_cur = den_r;
      D_T:     acc_cur = t_r;
      D_XN:    acc_cur = xn_r;
      D_YN:    acc_cur = yn_r;
      D_X:     acc_cur = x_r;
      D_LUM:   acc_cur = lum_r;
      D_C2:    acc_cur = c2_r;
      default: acc_cur = '0;
    endcase
    acc_new = cmd_i.op.sub ? acc_cur - term : acc_cur + term;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      st_r      <= in_sin_theta;
      ct_r      <= in_cos_theta;
      sp_r      <= in_sin_phi;
      cp_r      <= in_cos_phi;
      idx_r     <= in_cell_index;
      is_read_r <= (in_command == CMD_READ);
      sh_r  <= '0;
      ch_r  <= '0;
      q_r   <= '0;
      den_r <= DEN_INIT;
      t_r   <= '0;
      xn_r  <= '0;
      yn_r  <= '0;
      x_r   <= '0;
      lum_r <= '0;
      c2_r  <= '0;
    end else if (cmd_i.wb) begin
      case (cmd_i.op.dst)
        D_SH:    sh_r   <= acc_new;
        D_CH:    ch_r   <= acc_new;
        D_Q:     q_r    <= acc_new;
        D_DEN:   den_r  <= acc_new;
        D_T:     t_r    <= acc_new;
        D_XN:    xn_r   <= acc_new;
        D_YN:    yn_r   <= acc_new;
        D_X:     x_r    <= acc_new;
        D_LUM:   lum_r  <= acc_new;
        D_C2:    c2_r   <= acc_new;
        D_COLN:  coln_r <= prod_r[RAW_W-1:0];
        D_ROWN:  rown_r <= prod_r[RAW_W-1:0];
        D_BASE:  base_r <= prod_r[CELL_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.mul) begin
      prod_r <= prod;
    end
  end

  // Divider operands: depth reciprocal first, then column and row projections.
  assign coln_mag = coln_r[RAW_W-1] ? RAW_W'(-coln_r) : RAW_W'(coln_r);
  assign rown_mag = rown_r[RAW_W-1] ? RAW_W'(-rown_r) : RAW_W'(rown_r);

  always_comb begin
    case (cmd_i.div_sel)
      DV_DEPTH: begin
        div_n = DIVN_W'(1) << DEPTH_NUM_SH;
        div_d = DIVD_W'(den_r[DIVD_W-3:0]);
      end
      DV_COL: begin
        div_n = coln_mag[DIVN_W-1:0];
        div_d = {den_r[DIVD_W-3:0], 2'b00};
      end
      DV_ROW: begin
        div_n = rown_mag[DIVN_W-1:0];
        div_d = {den_r[DIVD_W-3:0], 2'b00};
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  tpz_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_i.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  // A negative numerator truncates toward zero, so it lands on cell zero only
  // when its magnitude is below the divisor.
  assign q_fits_w = (div_q < DIVN_W'(cfg.w));
  assign q_fits_h = (div_q < DIVN_W'(cfg.hg));

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (cmd_i.div_sel)
        DV_DEPTH: depth_r <= (div_q > DIVN_W'(DEPTH_MAX)) ? DEPTH_MAX
                                                          : div_q[DEPTH_BITS-1:0];
        DV_COL: begin
          col_r    <= div_q[COL_W-1:0];
          col_ok_r <= (!coln_r[RAW_W-1] || div_q == '0) && q_fits_w;
        end
        DV_ROW: begin
          row_r    <= div_q[ROW_W-1:0];
          row_ok_r <= (!rown_r[RAW_W-1] || div_q == '0) && q_fits_h;
        end
        default: ;
      endcase
    end
    if (cmd_i.addr) begin
      addr_r <= CELL_W'(col_r) + base_r;
    end
  end

  // Shade index: floor(lum / 2048) clamped to 0..11, stored one higher.
  assign lum_scaled = ACC_W'(lum_r >>> 11);
  always_comb begin
    if (lum_r[ACC_W-1]) begin
      shade = SHADE_W'(1);
    end else if (lum_scaled > ACC_W'(11)) begin
      shade = SHADE_W'(12);
    end else begin
      shade = SHADE_W'(lum_scaled[SHADE_W-1:0] + 1'b1);
    end
  end

  assign nearer = depth_r > rd_data_r[MEM_W-1:SHADE_W];
  assign we     = cmd_i.clr || (cmd_i.mem_cmp && nearer);
  assign wa     = cmd_i.clr ? clr_addr_r : addr_r;
  assign wd     = cmd_i.clr ? '0 : {depth_r, shade};
  assign ra     = is_read_r ? idx_r : addr_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd_i.mem_rd) begin
      rd_data_r <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plotted_r  <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      if (cmd_i.load) begin
        plotted_r  <= 1'b0;
        clr_addr_r <= '0;
      end else begin
        if (cmd_i.mem_cmp && nearer) begin
          plotted_r <= 1'b1;
        end
        if (cmd_i.clr) begin
          clr_addr_r <= clr_addr_r + 1'b1;
        end
      end
    end
  end

  assign sts.den_pos   = !den_r[ACC_W-1] && (den_r != '0);
  assign sts.div_done  = div_done;
  assign sts.on_screen = col_ok_r && row_ok_r;
  assign sts.clr_last  = (clr_addr_r == CELL_W'(CELLS - 1));

  assign res_glyph     = is_read_r ? glyph_of(rd_data_r[SHADE_W-1:0]) : '0;
  assign res_plotted   = plotted_r;
  assign res_cell_addr = plotted_r ? addr_r : '0;

`ifndef NO_ASSERTIONS
  a_write_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.mem_cmp && nearer) |-> (col_ok_r && row_ok_r && sts.den_pos))
    else $error("plot write without passing the screen tests");
  a_div_positive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.div_start |-> sts.den_pos)
    else $error("division started with a non-positive depth");
  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load |=> !plotted_r)
    else $error("plotted flag survived a new word");
  a_plot_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(plotted_r) |-> $past(cmd_i.mem_cmp && nearer))
    else $error("plotted flag set without a depth-test pass");
`endif

endmodule

>>> design/tpz_ctrl.sv
// Controller state machine: sequences clear, read and plot through the datapath.
// Depends on tpz_pkg for the command and status structs and the multiply schedule.
module tpz_ctrl import tpz_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_command,
  output logic       in_stall,
  input  logic       out_free,
  input  dp_sts_t    sts,
  output dp_cmd_t    cmd_o,
  output logic       res_take
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_CLR   = 14'b00000000000010,
    S_RD    = 14'b00000000000100,
    S_MUL   = 14'b00000000001000,
    S_WB    = 14'b00000000010000,
    S_DIVGO = 14'b00000000100000,
    S_DIV   = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_ADDR  = 14'b00000100000000,
    S_MRD   = 14'b00001000000000,
    S_CMP   = 14'b00010000000000,
    S_DONE  = 14'b00100000000000,
    S_SPARE0 = 14'b01000000000000,
    S_SPARE1 = 14'b10000000000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  div_sel_t              div_sel_r, div_sel_nxt;
  logic                  accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    div_sel_nxt = div_sel_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_command)
            CMD_CLEAR: state_nxt = S_CLR;
            CMD_PLOT: begin
              state_nxt = S_MUL;
              step_nxt  = '0;
            end
            CMD_READ:  state_nxt = S_RD;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_CLR:   if (sts.clr_last) state_nxt = S_DONE;
      S_RD:    state_nxt = S_DONE;
      S_MUL:   state_nxt = S_WB;
      S_WB: begin
        if (step_r == STEP_LUM_LAST && !sts.den_pos) begin
          state_nxt = S_DONE;
        end else if (step_r == STEP_ROWN) begin
          state_nxt   = S_DIVGO;
          div_sel_nxt = DV_DEPTH;
        end else if (step_r == STEP_BASE) begin
          state_nxt = S_ADDR;
        end else begin
          state_nxt = S_MUL;
          step_nxt  = step_r + 1'b1;
        end
      end
      S_DIVGO: state_nxt = S_DIV;
      S_DIV: begin
        if (sts.div_done) begin
          case (div_sel_r)
            DV_DEPTH: begin
              div_sel_nxt = DV_COL;
              state_nxt   = S_DIVGO;
            end
            DV_COL: begin
              div_sel_nxt = DV_ROW;
              state_nxt   = S_DIVGO;
            end
            default: state_nxt = S_CHK;
          endcase
        end
      end
      S_CHK: begin
        if (sts.on_screen) begin
          state_nxt = S_MUL;
          step_nxt  = STEP_BASE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ADDR:  state_nxt = S_MRD;
      S_MRD:   state_nxt = S_CMP;
      S_CMP:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      step_r    <= '0;
      div_sel_r <= DV_DEPTH;
    end else begin
      state_r   <= state_nxt;
      step_r    <= step_nxt;
      div_sel_r <= div_sel_nxt;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = accept;
    cmd_o.clr       = (state_r == S_CLR);
    cmd_o.mem_rd    = (state_r == S_RD) || (state_r == S_MRD);
    cmd_o.mul       = (state_r == S_MUL);
    cmd_o.wb        = (state_r == S_WB);
    cmd_o.op        = mul_op(step_r);
    cmd_o.div_start = (state_r == S_DIVGO);
    cmd_o.div_sel   = div_sel_r;
    cmd_o.addr      = (state_r == S_ADDR);
    cmd_o.mem_cmp   = (state_r == S_CMP);
  end

  assign res_take = (state_r == S_DONE) && out_free;

endmodule

>>> design/torus_point_zbuffer_renderer.sv
// Z-buffered torus point renderer: configuration registers, output register, control.
// Depends on tpz_pkg, tpz_ctrl and tpz_dp (which holds tpz_div and the frame store).
// One word is in work at a time. A clear sweeps the store a cell a cycle; a plot runs
// 21 multiplies, three divisions and a store read-compare-write. A plot behind the eye
// ends after the luminance multiplies, one off screen before the address multiply.
// Reset restores register defaults.
module torus_point_zbuffer_renderer import tpz_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel.
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic signed [15:0]  in_sin_theta,
  input  logic signed [15:0]  in_cos_theta,
  input  logic signed [15:0]  in_sin_phi,
  input  logic signed [15:0]  in_cos_phi,
  input  logic [14:0]         in_cell_index,
  // Result channel.
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          out_glyph,
  output logic                out_plotted,
  output logic [14:0]         out_cell_addr,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Reset (rst_n low, synchronous) clears control and loads the register
  // defaults; the frame store is undefined until a clear command sweeps it.
  // A new word is taken while a finished result waits in the output register.

  logic signed [15:0] a_sin_r, a_cos_r, b_sin_r, b_cos_r;
  logic [8:0]         cols_r;
  logic [7:0]         rows_r;
  logic               cfg_wr;
  cfg_t               cfg;

  logic               out_valid_r;
  logic [6:0]         out_glyph_r;
  logic               out_plotted_r;
  logic [14:0]        out_cell_addr_r;
  logic               out_free;
  logic               res_take;

  dp_cmd_t            dp_cmd;
  dp_sts_t            dp_sts;
  logic [GLYPH_W-1:0] res_glyph;
  logic               res_plotted;
  logic [CELL_W-1:0]  res_cell_addr;

  // Register writes complete in the access phase; the port never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_sin_r <= '0;
      a_cos_r <= 16'sd16384;
      b_sin_r <= '0;
      b_cos_r <= 16'sd16384;
      cols_r  <= 9'd80;
      rows_r  <= 8'd24;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_A_SIN: a_sin_r <= pwdata[15:0];
        REG_A_COS: a_cos_r <= pwdata[15:0];
        REG_B_SIN: b_sin_r <= pwdata[15:0];
        REG_B_COS: b_cos_r <= pwdata[15:0];
        REG_COLS:  cols_r  <= pwdata[8:0];
        REG_ROWS:  rows_r  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_A_SIN: prdata = {16'h0000, a_sin_r};
      REG_A_COS: prdata = {16'h0000, a_cos_r};
      REG_B_SIN: prdata = {16'h0000, b_sin_r};
      REG_B_COS: prdata = {16'h0000, b_cos_r};
      REG_COLS:  prdata = {23'h0, cols_r};
      REG_ROWS:  prdata = {24'h0, rows_r};
      default:   prdata = '0;
    endcase
  end

  // A screen larger than the frame store is clipped to the store's size.
  assign cfg.a_sin = a_sin_r;
  assign cfg.a_cos = a_cos_r;
  assign cfg.b_sin = b_sin_r;
  assign cfg.b_cos = b_cos_r;
  assign cfg.w     = (cols_r > 9'(MAX_COLS)) ? W_W'(MAX_COLS) : W_W'(cols_r);
  assign cfg.hg    = (rows_r > 8'(MAX_ROWS)) ? H_W'(MAX_ROWS) : H_W'(rows_r);

  tpz_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .out_free   (out_free),
    .sts        (dp_sts),
    .cmd_o      (dp_cmd),
    .res_take   (res_take)
  );

  tpz_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_i         (dp_cmd),
    .cfg           (cfg),
    .in_command    (in_command),
    .in_sin_theta  (in_sin_theta),
    .in_cos_theta  (in_cos_theta),
    .in_sin_phi    (in_sin_phi),
    .in_cos_phi    (in_cos_phi),
    .in_cell_index (in_cell_index),
    .sts           (dp_sts),
    .res_glyph     (res_glyph),
    .res_plotted   (res_plotted),
    .res_cell_addr (res_cell_addr)
  );

  // The output register holds a finished word while the sink stalls, so the
  // controller can already take and work on the next one.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_glyph_r     <= res_glyph;
      out_plotted_r   <= res_plotted;
      out_cell_addr_r <= res_cell_addr;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_glyph     = out_glyph_r;
  assign out_plotted   = out_plotted_r;
  assign out_cell_addr = out_cell_addr_r;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the torus point z-buffer renderer: directed and random frames with checking.
// Depends on tpz_pkg and torus_point_zbuffer_renderer; it predicts every result itself.
module tb_top;
  import tpz_pkg::*;

  // The run is aborted after this many clock cycles. The slowest correct run is
  // about a dozen clears plus fewer than 1050 plots (the word budget), with stalls.
  localparam int CYCLE_LIMIT  = 6000000;
  localparam int SETTLE       = 300;
  localparam int TARGET_WORDS = 1050;

  typedef struct packed {
    logic [6:0]  glyph;
    logic        plotted;
    logic [14:0] cell_addr;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_NOP;
  logic signed [15:0] in_sin_theta = '0;
  logic signed [15:0] in_cos_theta = '0;
  logic signed [15:0] in_sin_phi = '0;
  logic signed [15:0] in_cos_phi = '0;
  logic [14:0]        in_cell_index = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [6:0]  out_glyph;
  logic        out_plotted;
  logic [14:0] out_cell_addr;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  torus_point_zbuffer_renderer uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_sin_theta(in_sin_theta), .in_cos_theta(in_cos_theta),
    .in_sin_phi(in_sin_phi), .in_cos_phi(in_cos_phi), .in_cell_index(in_cell_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_glyph(out_glyph),
    .out_plotted(out_plotted), .out_cell_addr(out_cell_addr),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the configuration and of the frame store.
  logic signed [15:0] rot_as, rot_ac, rot_bs, rot_bc;
  logic [8:0]         scr_cols;
  logic [7:0]         scr_rows;
  logic [15:0]        depth_mem [CELLS];
  logic [3:0]         shade_mem [CELLS];

  frame_result_t pending_results[$];
  logic [14:0]   lit_cells[$];
  int            error_count = 0;
  int            words_sent = 0;
  int            cycle_count = 0;
  int            hold_cycles = 0;

  // Q1.14 product, floored back to Q1.14.
  function automatic longint fxmul(input longint a, input longint b);
    return (a * b) >>> 14;
  endfunction

  // ASCII shade ramp.
  function automatic logic [6:0] glyph_code(input logic [3:0] code);
    case (code)
      4'd1: return 7'd46;   4'd2: return 7'd44;   4'd3: return 7'd45;
      4'd4: return 7'd126;  4'd5: return 7'd58;   4'd6: return 7'd59;
      4'd7: return 7'd61;   4'd8: return 7'd33;   4'd9: return 7'd42;
      4'd10: return 7'd35;  4'd11: return 7'd36;  4'd12: return 7'd64;
      default: return 7'd32;
    endcase
  endfunction

  // Works out the result of one command and updates the shadow store the way
  // the block updates its frame store.
  function automatic frame_result_t render_word(input logic [1:0] cmd,
      input logic signed [15:0] s_th, input logic signed [15:0] c_th,
      input logic signed [15:0] s_ph, input logic signed [15:0] c_ph,
      input logic [14:0] idx);
    frame_result_t r;
    longint st, ct, sp, cp, sa, ca, sb, cb, w, hg;
    longint hh, sh, ch, q, den, t, xn, yn, lum, n, d, col, row, o;
    r = '0;
    case (cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          depth_mem[i] = '0;
          shade_mem[i] = '0;
        end
      end
      CMD_READ: r.glyph = glyph_code(shade_mem[idx]);
      CMD_PLOT: begin
        st = s_th; ct = c_th; sp = s_ph; cp = c_ph;
        sa = rot_as; ca = rot_ac; sb = rot_bs; cb = rot_bc;
        w  = (scr_cols > MAX_COLS) ? MAX_COLS : scr_cols;
        hg = (scr_rows > MAX_ROWS) ? MAX_ROWS : scr_rows;
        hh = cp + 2 * 16384;
        sh = fxmul(st, hh);
        ch = fxmul(ct, hh);
        q  = fxmul(st, cp);
        den = fxmul(sh, sa) + fxmul(sp, ca) + 5 * 16384;
        t   = fxmul(sh, ca) - fxmul(sp, sa);
        xn  = fxmul(ch, cb) - fxmul(t, sb);
        yn  = fxmul(ch, sb) + fxmul(t, cb);
        lum = fxmul(fxmul(sp, sa) - fxmul(q, ca), cb) - fxmul(q, sa) - fxmul(sp, ca)
              - fxmul(fxmul(ct, cp), sb);
        n = (8 * lum) / 16384;
        if (n < 0) n = 0;
        if (n > 11) n = 11;
        // A point at or behind the eye is never drawn.
        if (den > 0) begin
          d = (longint'(1) << 29) / den;
          if (d > 65535) d = 65535;
          col = (2 * w * den + w * xn) / (4 * den);
          row = (2 * hg * den + hg * yn) / (4 * den);
          if (row >= 0 && row < hg && col >= 0 && col < w) begin
            o = col + w * row;
            if (d > depth_mem[o]) begin
              depth_mem[o] = d[15:0];
              shade_mem[o] = n[3:0] + 4'd1;
              r.plotted = 1'b1;
              r.cell_addr = o[14:0];
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int expv, input int gotv);
    $display("MISMATCH at cycle %0d: %s expected %0d got %0d", cycle_count, what, expv, gotv);
    error_count++;
  endtask

  // Cycle counter and watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result checker: every accepted result word is compared with the oldest prediction.
  always @(posedge clk) begin
    frame_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("MISMATCH at cycle %0d: result word with nothing expected", cycle_count);
        error_count++;
      end else begin
        e = pending_results.pop_front();
        if (out_glyph !== e.glyph) report_mismatch("glyph", e.glyph, out_glyph);
        if (out_plotted !== e.plotted) report_mismatch("plotted", e.plotted, out_plotted);
        if (out_cell_addr !== e.cell_addr)
          report_mismatch("cell_addr", e.cell_addr, out_cell_addr);
      end
    end
  end

  // Receiver side. A forced hold-off from a test wins; otherwise the stall
  // pattern switches between random moods: no stalls, light, or heavy.
  always @(negedge clk) begin
    int mood, left, pct;
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      if (left == 0) begin
        mood = $urandom_range(0, 9);
        left = $urandom_range(10, 80);
      end
      left = left - 1;
      pct = (mood < 4) ? 0 : (mood < 8) ? 25 : 85;
      out_stall <= ($urandom_range(0, 99) < pct);
    end
  end

  // Sender gap: mostly none or short, now and then long.
  task automatic sender_gap();
    int r, n;
    r = $urandom_range(0, 99);
    n = (r < 50) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (n > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Offers one word and waits until the block takes it; the prediction is made
  // at acceptance. Valid is left high so back-to-back words need no bubble.
  task automatic send_word(input logic [1:0] cmd, input logic signed [15:0] s_th,
      input logic signed [15:0] c_th, input logic signed [15:0] s_ph,
      input logic signed [15:0] c_ph, input logic [14:0] idx);
    frame_result_t r;
    sender_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_sin_theta <= s_th;
    in_cos_theta <= c_th;
    in_sin_phi <= s_ph;
    in_cos_phi <= c_ph;
    in_cell_index <= idx;
    do @(posedge clk); while (in_stall);
    r = render_word(cmd, s_th, c_th, s_ph, c_ph, idx);
    pending_results.push_back(r);
    if (r.plotted) begin
      lit_cells.push_back(r.cell_addr);
      if (lit_cells.size() > 64) void'(lit_cells.pop_front());
    end
    words_sent++;
  endtask

  // Pauses the sender until every expected result is in, then lets the block settle.
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Loads a full frame setup. Only called while the block is idle.
  task automatic set_frame(input logic signed [15:0] as, input logic signed [15:0] ac,
      input logic signed [15:0] bs, input logic signed [15:0] bc,
      input logic [8:0] cols, input logic [7:0] rows);
    drain();
    write_reg(REG_A_SIN, 32'(as)); rot_as = as;
    write_reg(REG_A_COS, 32'(ac)); rot_ac = ac;
    write_reg(REG_B_SIN, 32'(bs)); rot_bs = bs;
    write_reg(REG_B_COS, 32'(bc)); rot_bc = bc;
    write_reg(REG_COLS, 32'(cols)); scr_cols = cols;
    write_reg(REG_ROWS, 32'(rows)); scr_rows = rows;
  endtask

  function automatic logic signed [15:0] q14_sin(input real a);
    return 16'($rtoi($floor(16384.0 * $sin(a) + 0.5)));
  endfunction

  function automatic logic signed [15:0] q14_cos(input real a);
    return 16'($rtoi($floor(16384.0 * $cos(a) + 0.5)));
  endfunction

  function automatic real rand_angle();
    return $urandom_range(0, 62831) / 10000.0;
  endfunction

  task automatic set_random_frame(input logic [8:0] cols, input logic [7:0] rows);
    real a, b;
    a = rand_angle();
    b = rand_angle();
    set_frame(q14_sin(a), q14_cos(a), q14_sin(b), q14_cos(b), cols, rows);
  endtask

  // A proper surface point from two random angles, or, when noisy, raw
  // 16-bit patterns that may leave the unit circle entirely.
  task automatic send_plot(input bit noisy);
    real th, ph;
    if (noisy) begin
      send_word(CMD_PLOT, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom));
    end else begin
      th = rand_angle();
      ph = rand_angle();
      send_word(CMD_PLOT, q14_sin(th), q14_cos(th), q14_sin(ph), q14_cos(ph),
                15'($urandom));
    end
  endtask

  // Reads mostly hit cells that were recently drawn, so glyphs other than blank show up.
  task automatic send_read();
    logic [14:0] idx;
    if (lit_cells.size() != 0 && $urandom_range(0, 99) < 65)
      idx = lit_cells[$urandom_range(0, lit_cells.size() - 1)];
    else
      idx = 15'($urandom);
    send_word(CMD_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), idx);
  endtask

  task automatic send_mix(input int count);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 70) send_plot(1'b0);
      else if (r < 80) send_plot(1'b1);
      else if (r < 96) send_read();
      else send_word(CMD_NOP, 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 15'($urandom));
    end
  endtask

  // The register defaults from reset; the store is swept clean before any plot or read.
  task automatic test_reset_frame();
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
    send_word(CMD_READ, '0, '0, '0, '0, 15'd0);
    send_word(CMD_READ, '0, '0, '0, '0, 15'h7fff);
    send_word(CMD_PLOT, '0, 16'sd16384, '0, 16'sd16384, '0);
    send_word(CMD_PLOT, '0, 16'sd16384, '0, 16'sd16384, '0);
    send_word(CMD_PLOT, 16'sd16384, '0, -16'sd16384, '0, '0);
    send_word(CMD_PLOT, -16'sd16384, '0, 16'sd16384, '0, '0);
    send_word(CMD_NOP, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 15'h7fff);
    send_read();
    send_read();
  endtask

  // Field and register extremes: points behind the eye, shade beyond the ramp,
  // a screen larger than the store, and a screen of zero width or height.
  task automatic test_extremes();
    set_frame(16'sd16384, 16'sd16384, -16'sd16384, -16'sd16384, 9'd511, 8'd255);
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
    send_word(CMD_PLOT, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, '0);
    send_word(CMD_PLOT, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, '0);
    send_word(CMD_PLOT, -16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384, '0);
    send_word(CMD_PLOT, 16'sd16384, -16'sd16384, 16'sd16384, -16'sd16384, '0);
    send_word(CMD_PLOT, '0, '0, '0, '0, '0);
    send_read();
    send_read();
    set_frame(-16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 9'd0, 8'd24);
    send_word(CMD_PLOT, '0, 16'sd16384, '0, 16'sd16384, '0);
    set_frame(16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 9'd256, 8'd0);
    send_word(CMD_PLOT, '0, 16'sd16384, '0, 16'sd16384, '0);
    set_frame(16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 9'd1, 8'd1);
    send_word(CMD_PLOT, '0, 16'sd16384, '0, 16'sd16384, '0);
    send_word(CMD_READ, '0, '0, '0, '0, 15'd0);
  endtask

  // A handful of screen shapes, the first and last on a freshly cleared store.
  task automatic test_screen_sweep();
    set_random_frame(9'd256, 8'd128);
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
    send_mix(70);
    set_random_frame(9'd7, 8'd3);
    send_mix(50);
    set_random_frame(9'($urandom_range(1, 511)), 8'($urandom_range(1, 255)));
    send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
    send_mix(70);
  endtask

  // The receiver holds off for a long time while words keep coming, so the
  // block fills and stalls its input; afterwards the sender waits for everything.
  task automatic test_backpressure();
    drain();
    @(negedge clk) hold_cycles <= 3000;
    send_mix(12);
    drain();
  endtask

  // Whole random frames until the word budget is used up; the last frame is cut short.
  task automatic test_random_frames();
    while (words_sent < TARGET_WORDS) begin
      set_random_frame(($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 511)) : 9'd80,
                       ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'd24);
      send_word(CMD_CLEAR, '0, '0, '0, '0, '0);
      send_mix((TARGET_WORDS - words_sent < 180) ? TARGET_WORDS - words_sent : 180);
    end
  endtask

  initial begin
    rot_as = '0; rot_ac = 16'sd16384; rot_bs = '0; rot_bc = 16'sd16384;
    scr_cols = 9'd80; scr_rows = 8'd24;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    test_reset_frame();
    test_extremes();
    test_screen_sweep();
    test_backpressure();
    test_random_frames();
    drain();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
